// File: hdl/wsvs_pkg.sv
// Shared types, constants and a helper function of the victim selector.
package wsvs_pkg;

  localparam int QUEUES      = 8;
  localparam int QUEUE_DEPTH = 16384;
  localparam int OCC_W       = $clog2(QUEUE_DEPTH);
  localparam int Q_IDX_W     = $clog2(QUEUES);
  localparam int CNT_W       = $clog2(QUEUES + 1);
  localparam int SEED_W      = 31;
  localparam int SEED_DEPTH  = 8;
  localparam int SEED_AW     = $clog2(SEED_DEPTH);
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  // Park-Miller minimal standard generator
  localparam logic [14:0]       PM_A  = 15'd16807;
  localparam logic [SEED_W-1:0] PM_M  = 31'h7FFF_FFFF;
  localparam int                PROD_W = SEED_W + 15;

  localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(QUEUES);

  // operation codes
  localparam logic OP_CHOOSE    = 1'b0;
  localparam logic OP_LOAD_SEED = 1'b1;

  // steal policies
  localparam logic [1:0] POL_BEST2 = 2'd0;
  localparam logic [1:0] POL_ALL   = 2'd1;
  localparam logic [1:0] POL_ONE   = 2'd2;

  // register index (paddr[2])
  localparam logic REG_ACTIVE = 1'b0;
  localparam logic REG_POLICY = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [2:0]        thief;
    logic [SEED_W-1:0] seed_value;
    logic [OCC_W-1:0]  occupancy_q0;
    logic [OCC_W-1:0]  occupancy_q1;
    logic [OCC_W-1:0]  occupancy_q2;
    logic [OCC_W-1:0]  occupancy_q3;
    logic [OCC_W-1:0]  occupancy_q4;
    logic [OCC_W-1:0]  occupancy_q5;
    logic [OCC_W-1:0]  occupancy_q6;
    logic [OCC_W-1:0]  occupancy_q7;
  } in_item_t;

  typedef struct packed {
    logic       victim_found;
    logic [2:0] victim;
    logic       victim_nonempty;
  } out_item_t;

  // One radix-16 remainder step: (rem*16 + nib) mod n, with rem < n <= 8.
  function automatic logic [2:0] mod_step(input logic [2:0] rem, input logic [3:0] nib,
                                          input logic [CNT_W-1:0] n);
    logic [7:0] v;
    logic [7:0] d;
    v = {1'b0, rem, nib};
    for (int k = 4; k >= 0; k--) begin
      d = 8'(n) << k;
      if (v >= d) v = v - d;
    end
    return v[2:0];
  endfunction

endpackage

// File: hdl/wsvs_seed_bank.sv
// Per-thief generator seed registers, reset to one.
module wsvs_seed_bank import wsvs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               we,
  input  logic [SEED_AW-1:0] waddr,
  input  logic [SEED_W-1:0]  wdata,
  input  logic [SEED_AW-1:0] raddr,
  output logic [SEED_W-1:0]  rdata
);

  logic [SEED_W-1:0] seed_r [SEED_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SEED_DEPTH; i++) seed_r[i] <= SEED_W'(1);
    end else if (we) begin
      seed_r[waddr] <= wdata;
    end
  end

  assign rdata = seed_r[raddr];

endmodule

// File: hdl/wsvs_draw_unit.sv
// Shared draw unit: next Park-Miller seed, then its remainder modulo the queue count.
module wsvs_draw_unit import wsvs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SEED_W-1:0]  seed,
  input  logic [CNT_W-1:0]   n,
  output logic               done,
  output logic [SEED_W-1:0]  new_seed,
  output logic [Q_IDX_W-1:0] draw
);

  typedef enum logic [1:0] {D_IDLE, D_MUL, D_FOLD, D_MOD} dstate_t;

  dstate_t           state_r;
  logic [SEED_W-1:0] seed_r;
  logic [CNT_W-1:0]  n_r;
  logic [PROD_W-1:0] prod_r;
  logic [2:0]        rem_r;
  logic [2:0]        cnt_r;
  logic              done_r;

  logic [SEED_W:0]   sum;
  logic [SEED_W-1:0] folded;
  logic [SEED_W:0]   padded;
  logic [3:0]        nib;

  // 16807*s mod 2^31-1: add the high part onto the low 31 bits, one correction
  assign sum    = {1'b0, prod_r[SEED_W-1:0]} + (SEED_W+1)'(prod_r[PROD_W-1:SEED_W]);
  assign folded = (sum >= {1'b0, PM_M}) ? SEED_W'(sum - {1'b0, PM_M}) : sum[SEED_W-1:0];

  // nibbles taken from the top, 8 per 32-bit padded seed
  assign padded = {1'b0, seed_r};
  assign nib    = padded[{~cnt_r, 2'b00} +: 4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            seed_r  <= seed;
            n_r     <= n;
            state_r <= D_MUL;
          end
        end
        D_MUL: begin
          prod_r  <= seed_r * PM_A;
          state_r <= D_FOLD;
        end
        D_FOLD: begin
          seed_r  <= folded;
          rem_r   <= 3'd0;
          cnt_r   <= 3'd0;
          state_r <= D_MOD;
        end
        D_MOD: begin
          rem_r <= mod_step(rem_r, nib, n_r);
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign done     = done_r;
  assign new_seed = seed_r;
  assign draw     = Q_IDX_W'(rem_r);

endmodule

// File: hdl/work_stealing_victim_selector.sv
// Top level of the work-stealing victim selector.
//
// Use: a request beat on in_* names a thief queue and carries all eight
// queue occupancies; one result beat on out_* gives the victim (or none).
// A load-seed beat stores the thief's generator seed and returns an
// all-zero result. Registers active_queues (addr 0) and steal_policy
// (addr 4) sit behind the APB port, pready tied high, zero wait states.
// One beat is worked on at a time; in_stall is high from accept until
// the result has moved into the output register.
// Seed loads and one or two active queues go straight to the finish
// state; fullest-of-all makes one compare per queue; each random draw
// attempt runs start, multiply, fold, eight radix-16 remainder steps and
// done, and a draw that hits the thief or the first pick is redrawn;
// the finish state then hands the result to the output register.
// The next beat can be taken while out_valid is high, since in_stall
// drops when the result enters the output register.
// A stalled output holds its beat; the next request may still be taken
// and waits in its finish state until the output register frees up.
// Reset: all seeds to 1, active_queues to 8, steal_policy to best of two,
// output empty.
module work_stealing_victim_selector import wsvs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAW_GO, S_DRAW_WAIT, S_FINISH} state_t;

  state_t             state_r;
  in_item_t           item_r;
  logic [Q_IDX_W-1:0] idx_r;
  logic [OCC_W-1:0]   best_r;
  logic [Q_IDX_W-1:0] victim_r;
  logic               found_r;
  logic               second_r;
  logic [Q_IDX_W-1:0] k1_r;
  out_item_t          out_r;
  logic               out_valid_r;
  logic [CNT_W-1:0]   active_r;
  logic [1:0]         policy_r;

  logic               in_accept;
  logic               cfg_wr;
  logic [CNT_W-1:0]   n_eff;
  logic [OCC_W-1:0]   occ [QUEUES];
  logic               scan_take;
  logic [SEED_W-1:0]  in_seed;

  logic               seed_we;
  logic [SEED_AW-1:0] seed_waddr;
  logic [SEED_W-1:0]  seed_wdata;
  logic [SEED_W-1:0]  seed_rdata;

  logic               draw_done;
  logic [SEED_W-1:0]  draw_seed;
  logic [Q_IDX_W-1:0] draw_q;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
      policy_r <= POL_BEST2;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ACTIVE: active_r <= pwdata[CNT_W-1:0];
        REG_POLICY: policy_r <= pwdata[1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ACTIVE: prdata = CFG_DW'(active_r);
      REG_POLICY: prdata = CFG_DW'(policy_r);
      default:    prdata = '0;
    endcase
  end

  // zero counts as one queue, anything past QUEUES as QUEUES
  always_comb begin
    if (active_r == '0)
      n_eff = CNT_W'(1);
    else if (active_r > CNT_W'(QUEUES))
      n_eff = CNT_W'(QUEUES);
    else
      n_eff = active_r;
  end

  // ---------------- latched request ----------------
  assign occ[0] = item_r.occupancy_q0;
  assign occ[1] = item_r.occupancy_q1;
  assign occ[2] = item_r.occupancy_q2;
  assign occ[3] = item_r.occupancy_q3;
  assign occ[4] = item_r.occupancy_q4;
  assign occ[5] = item_r.occupancy_q5;
  assign occ[6] = item_r.occupancy_q6;
  assign occ[7] = item_r.occupancy_q7;

  // zero and 2^31-1, which lock the generator at zero, are stored as 1
  assign in_seed = (in_data.seed_value == '0 || in_data.seed_value == PM_M) ?
                   SEED_W'(1) : in_data.seed_value;

  // ---------------- seed bank ----------------
  // seed loads come only in idle, write-backs only mid draw: never both
  assign seed_we    = (in_accept && in_data.operation == OP_LOAD_SEED) || draw_done;
  assign seed_waddr = draw_done ? item_r.thief : in_data.thief;
  assign seed_wdata = draw_done ? draw_seed : in_seed;

  wsvs_seed_bank u_seeds (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (seed_we),
    .waddr (seed_waddr),
    .wdata (seed_wdata),
    .raddr (item_r.thief),
    .rdata (seed_rdata)
  );

  wsvs_draw_unit u_draw (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_DRAW_GO),
    .seed     (seed_rdata),
    .n        (n_eff),
    .done     (draw_done),
    .new_seed (draw_seed),
    .draw     (draw_q)
  );

  // fullest-of-all: strictly greater wins, so ties keep the lower index
  assign scan_take = (idx_r != item_r.thief) && (occ[idx_r] > best_r);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // the finish state reloads the output register itself
      if (out_valid_r && !out_stall && state_r != S_FINISH) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            item_r   <= in_data;
            found_r  <= 1'b0;
            victim_r <= '0;
            best_r   <= '0;
            idx_r    <= '0;
            second_r <= 1'b0;
            if (in_data.operation == OP_LOAD_SEED) begin
              state_r <= S_FINISH;
            end else if (n_eff == CNT_W'(1)) begin
              state_r <= S_FINISH;
            end else if (n_eff == CNT_W'(2)) begin
              // only the other of queues 0 and 1
              found_r  <= 1'b1;
              victim_r <= {{(Q_IDX_W-1){1'b0}}, ~in_data.thief[0]};
              state_r  <= S_FINISH;
            end else if (policy_r == POL_ALL) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_DRAW_GO;
            end
          end
        end

        S_SCAN: begin
          if (scan_take) begin
            best_r   <= occ[idx_r];
            victim_r <= idx_r;
          end
          idx_r <= idx_r + Q_IDX_W'(1);
          if (CNT_W'(idx_r) == n_eff - CNT_W'(1)) begin
            found_r <= (best_r != '0) || scan_take;
            state_r <= S_FINISH;
          end
        end

        S_DRAW_GO: state_r <= S_DRAW_WAIT;

        S_DRAW_WAIT: begin
          if (draw_done) begin
            if (!second_r) begin
              if (draw_q == item_r.thief) begin
                state_r <= S_DRAW_GO;
              end else begin
                k1_r <= draw_q;
                if (policy_r == POL_ONE) begin
                  victim_r <= draw_q;
                  found_r  <= 1'b1;
                  state_r  <= S_FINISH;
                end else begin
                  second_r <= 1'b1;
                  state_r  <= S_DRAW_GO;
                end
              end
            end else begin
              if (draw_q == item_r.thief || draw_q == k1_r) begin
                state_r <= S_DRAW_GO;
              end else begin
                // tie goes to the first draw
                victim_r <= (occ[draw_q] > occ[k1_r]) ? draw_q : k1_r;
                found_r  <= 1'b1;
                state_r  <= S_FINISH;
              end
            end
          end
        end

        S_FINISH: begin
          if (!out_valid_r || !out_stall) begin
            out_r.victim_found    <= found_r;
            out_r.victim          <= 3'(victim_r);
            out_r.victim_nonempty <= found_r && (occ[victim_r] != '0);
            out_valid_r           <= 1'b1;
            state_r               <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/wsvs_checker.sv
// Port-level checker for the victim selector, bound to the top level.
module wsvs_checker import wsvs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input out_item_t         out_data
);

  // reset empties the output and opens the input
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("output or stall not cleared by reset");

  // one beat at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // a result never shows up the cycle right after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result appeared too early");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat dropped or changed");

endmodule

bind work_stealing_victim_selector wsvs_checker u_wsvs_checker (.*);
